FILE: rtl/dcnp_pkg.sv
// Shared types and constants of the drill coordinate number parser.
package dcnp_pkg;

    // ASCII codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // units register codes
    localparam logic [1:0] UNITS_UNKNOWN = 2'd0;
    localparam logic [1:0] UNITS_METRIC  = 2'd1;
    localparam logic [1:0] UNITS_INCH    = 2'd2;

    // number format codes
    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_2_4     = 2'd1;
    localparam logic [1:0] FMT_3_2     = 2'd2;
    localparam logic [1:0] FMT_3_3     = 2'd3;

    // configuration register indexes
    localparam logic CFG_UNITS        = 1'b0;
    localparam logic CFG_START_FORMAT = 1'b1;

    localparam logic [31:0] ACC_CAP = 32'hFFFF_FFFF;

    // integer part scale: inch 10000 * 254 / 100, metric 1000, format 3.2 ten
    localparam logic [14:0] KMUL_INCH   = 15'd25400;
    localparam logic [14:0] KMUL_METRIC = 15'd1000;
    localparam logic [14:0] KMUL_TEN    = 15'd10;

    // floor(b * 127 / 50) == (b * CINV) >> 33 for b below one million
    localparam logic [34:0] CINV       = 35'd21818433884;
    localparam int          CINV_SHIFT = 33;

    typedef enum logic [1:0] {
        K_INCH,
        K_METRIC,
        K_TEN
    } t_kcode;

    // operands of one closed number, handed to the scaling pipeline
    typedef struct packed {
        logic [31:0] a;      // multiplied by the kcode constant
        t_kcode      kcode;
        logic [19:0] b;      // addend, scaled by 254/100 when inch
        logic        inch;
        logic        neg;
        logic        ok;
        logic        over;
        logic [1:0]  fmt;
    } t_op;

endpackage

FILE: rtl/dcnp_if.sv
// Channel interfaces: character beats in, coordinate beats out.
interface dcnp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, character, last, input ready);
    modport sink   (input valid, character, last, output ready);
endinterface

interface dcnp_out_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         valid_res;
    logic [1:0]                   format_used;
    logic                         saturated;

    modport source (output valid, value, valid_res, format_used, saturated, input ready);
    modport sink   (input valid, value, valid_res, format_used, saturated, output ready);
endinterface

FILE: rtl/drill_coordinate_number_parser_top.sv
// Top level of the drill coordinate number parser.
// Throughput: one character beat per cycle, back to back, any mix of numbers,
//   while the operand register can take the number's closing beat. The beat
//   with last passes the input, operand, multiply and result registers in turn.
// Reset (synchronous, active low): clears all valid flags, units and format to
//   unknown, and the per-number accumulators; no clearing pass.
module drill_coordinate_number_parser_top
    import dcnp_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port: index 0 units, index 1 start_format
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    // character beats
    dcnp_in_if.sink    i_chr,
    // coordinate beats
    dcnp_out_if.source o_res
);

    // Closed-number operands travel from the character stage to the scaling
    // pipeline through a registered valid/ready hop.
    logic op_valid;
    logic op_ready;
    t_op  op;

    // Character stage: each beat updates the accumulators; the beat with last
    // also picks the scale constant and format for the number.
    dcnp_char_stage u_char (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_chr      (i_chr),
        .o_op_valid (op_valid),
        .o_op       (op),
        .i_op_ready (op_ready)
    );

    // Scaling: one 32x15 multiply and the inch 254/100 reciprocal multiply in
    // parallel, then add, clip to the signed range and apply the sign.
    dcnp_scale_stage #(
        .VALUE_BITS (VALUE_BITS)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_op_ready (op_ready),
        .o_res      (o_res)
    );

endmodule

FILE: rtl/dcnp_char_stage.sv
// Character stage: input register, per-number accumulators, close decision.
module dcnp_char_stage
    import dcnp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [1:0]     i_cfg_data,
    dcnp_in_if.sink        i_chr,
    output logic           o_op_valid,
    output t_op            o_op,
    input  logic           i_op_ready
);

    // input register
    logic       r_v0;
    logic [7:0] r_ch;
    logic       r_last;

    // configuration
    logic [1:0] r_units;
    logic [1:0] r_fmt;

    // number state
    logic        r_neg,   n_neg;
    logic        r_first, n_first;
    logic        r_point, n_point;
    logic [31:0] r_acc,   n_acc;
    logic [3:0]  r_l1,    n_l1;
    logic [6:0]  r_l2,    n_l2;
    logic [9:0]  r_l3,    n_l3;
    logic [13:0] r_l4,    n_l4;
    logic [16:0] r_l5,    n_l5;
    logic [19:0] r_l6,    n_l6;
    logic [3:0]  r_dcnt,  n_dcnt;
    logic        r_fdz,   n_fdz;
    logic [13:0] r_frac,  n_frac;
    logic [9:0]  r_f3,    n_f3;
    logic [2:0]  r_fcnt,  n_fcnt;
    logic        r_bad,   n_bad;

    // output register
    logic r_op_v;
    t_op  r_op;

    logic        w_fire;
    logic        w_op_en;
    logic [3:0]  w_d;
    logic        w_is_digit;
    logic [35:0] w_acc10;
    logic [19:0] w_fpad_inch;
    logic [19:0] w_fpad_metric;
    logic [1:0]  w_fmt_after;
    t_op         w_op;

    assign w_op_en     = !r_op_v || i_op_ready;
    assign w_fire      = r_v0 && (!r_last || w_op_en);
    assign i_chr.ready = !r_v0 || w_fire;
    assign o_op_valid  = r_op_v;
    assign o_op        = r_op;

    assign w_d        = r_ch[3:0];
    assign w_is_digit = (r_ch >= CH_0) && (r_ch <= CH_9);
    assign w_acc10    = 36'(r_acc) * 36'd10 + 36'(w_d);

    // state update for the character in the input register
    always_comb begin
        n_neg   = r_neg;
        n_first = 1'b0;
        n_point = r_point;
        n_acc   = r_acc;
        n_l1    = r_l1;
        n_l2    = r_l2;
        n_l3    = r_l3;
        n_l4    = r_l4;
        n_l5    = r_l5;
        n_l6    = r_l6;
        n_dcnt  = r_dcnt;
        n_fdz   = r_fdz;
        n_frac  = r_frac;
        n_f3    = r_f3;
        n_fcnt  = r_fcnt;
        n_bad   = r_bad;
        priority if (r_first && (r_ch == CH_PLUS || r_ch == CH_MINUS)) begin
            n_neg = (r_ch == CH_MINUS);
        end else if (w_is_digit) begin
            if (!r_point) begin
                if (r_dcnt == 4'd0) begin
                    n_fdz = (w_d == 4'd0);
                end
                n_acc = (w_acc10 > 36'(ACC_CAP)) ? ACC_CAP : w_acc10[31:0];
                // last k digits: previous last k-1 digits shifted up one place
                n_l1  = w_d;
                n_l2  = 7'(r_l1) * 7'd10 + 7'(w_d);
                n_l3  = 10'(r_l2) * 10'd10 + 10'(w_d);
                n_l4  = 14'(r_l3) * 14'd10 + 14'(w_d);
                n_l5  = 17'(r_l4) * 17'd10 + 17'(w_d);
                n_l6  = 20'(r_l5) * 20'd10 + 20'(w_d);
                if (r_dcnt != 4'd15) begin
                    n_dcnt = r_dcnt + 4'd1;
                end
            end else if (r_fcnt < 3'd4) begin
                n_frac = 14'(r_frac * 14'd10) + 14'(w_d);
                if (r_fcnt < 3'd3) begin
                    n_f3 = 10'(r_f3 * 10'd10) + 10'(w_d);
                end
                n_fcnt = r_fcnt + 3'd1;
            end
        end else if (r_ch == CH_POINT && !r_point) begin
            n_point = 1'b1;
        end else begin
            n_bad = 1'b1;
        end
    end

    // fraction padded to four (inch) or three (metric) digits
    always_comb begin
        unique case (n_fcnt)
            3'd1:    w_fpad_inch = 20'(n_frac) * 20'd1000;
            3'd2:    w_fpad_inch = 20'(n_frac) * 20'd100;
            3'd3:    w_fpad_inch = 20'(n_frac) * 20'd10;
            3'd4:    w_fpad_inch = 20'(n_frac);
            default: w_fpad_inch = '0;
        endcase
        unique case (n_fcnt)
            3'd0:    w_fpad_metric = '0;
            3'd1:    w_fpad_metric = 20'(n_f3) * 20'd100;
            3'd2:    w_fpad_metric = 20'(n_f3) * 20'd10;
            default: w_fpad_metric = 20'(n_f3);
        endcase
    end

    // close decision
    always_comb begin
        w_fmt_after = r_fmt;
        w_op        = '0;
        w_op.kcode  = K_TEN;
        priority if (n_bad) begin
            w_op.ok = 1'b0;
        end else if (r_units == UNITS_INCH) begin
            w_op.ok    = 1'b1;
            w_op.inch  = 1'b1;
            w_op.kcode = K_INCH;
            if (n_point) begin
                w_op.a    = n_acc;
                w_op.b    = w_fpad_inch;
                w_op.over = (n_acc == ACC_CAP);
            end else begin
                w_op.b = n_l6;
            end
        end else if (r_units == UNITS_METRIC) begin
            if (n_point) begin
                w_op.ok    = 1'b1;
                w_op.kcode = K_METRIC;
                w_op.a     = n_acc;
                w_op.b     = w_fpad_metric;
                w_op.over  = (n_acc == ACC_CAP);
            end else if (r_fmt == FMT_3_2) begin
                w_op.ok = 1'b1;
                w_op.a  = 32'(n_l5);
            end else if (r_fmt == FMT_3_3) begin
                w_op.ok = 1'b1;
                w_op.b  = n_l6;
            end else if (n_dcnt == 4'd6) begin
                w_fmt_after = FMT_3_3;
                w_op.ok     = 1'b1;
                w_op.b      = n_l6;
            end else if (n_dcnt == 4'd5 && n_fdz) begin
                w_fmt_after = FMT_3_2;
                w_op.ok     = 1'b1;
                w_op.a      = 32'(n_l5);
            end else begin
                w_op.ok = 1'b0;
            end
        end else begin
            w_op.ok = 1'b0;
        end
        w_op.neg = n_neg;
        w_op.fmt = w_fmt_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_op_v  <= 1'b0;
            r_units <= UNITS_UNKNOWN;
            r_fmt   <= FMT_UNKNOWN;
            r_neg   <= 1'b0;
            r_first <= 1'b1;
            r_point <= 1'b0;
            r_acc   <= '0;
            r_l1    <= '0;
            r_l2    <= '0;
            r_l3    <= '0;
            r_l4    <= '0;
            r_l5    <= '0;
            r_l6    <= '0;
            r_dcnt  <= '0;
            r_fdz   <= 1'b0;
            r_frac  <= '0;
            r_f3    <= '0;
            r_fcnt  <= '0;
            r_bad   <= 1'b0;
        end else begin
            if (i_chr.valid && i_chr.ready) begin
                r_v0 <= 1'b1;
            end else if (w_fire) begin
                r_v0 <= 1'b0;
            end

            if (w_fire && r_last) begin
                r_op_v <= 1'b1;
            end else if (i_op_ready) begin
                r_op_v <= 1'b0;
            end

            if (w_fire) begin
                if (r_last) begin
                    r_fmt   <= w_fmt_after;
                    r_neg   <= 1'b0;
                    r_first <= 1'b1;
                    r_point <= 1'b0;
                    r_acc   <= '0;
                    r_l1    <= '0;
                    r_l2    <= '0;
                    r_l3    <= '0;
                    r_l4    <= '0;
                    r_l5    <= '0;
                    r_l6    <= '0;
                    r_dcnt  <= '0;
                    r_fdz   <= 1'b0;
                    r_frac  <= '0;
                    r_f3    <= '0;
                    r_fcnt  <= '0;
                    r_bad   <= 1'b0;
                end else begin
                    r_neg   <= n_neg;
                    r_first <= n_first;
                    r_point <= n_point;
                    r_acc   <= n_acc;
                    r_l1    <= n_l1;
                    r_l2    <= n_l2;
                    r_l3    <= n_l3;
                    r_l4    <= n_l4;
                    r_l5    <= n_l5;
                    r_l6    <= n_l6;
                    r_dcnt  <= n_dcnt;
                    r_fdz   <= n_fdz;
                    r_frac  <= n_frac;
                    r_f3    <= n_f3;
                    r_fcnt  <= n_fcnt;
                    r_bad   <= n_bad;
                end
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_UNITS:        r_units <= i_cfg_data;
                    CFG_START_FORMAT: r_fmt   <= i_cfg_data;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_chr.valid && i_chr.ready) begin
            r_ch   <= i_chr.character;
            r_last <= i_chr.last;
        end
        if (w_fire && r_last) begin
            r_op <= w_op;
        end
    end

endmodule

FILE: rtl/dcnp_scale_stage.sv
// Scaling pipeline: multiply stage, then sum, saturate and sign into the result register.
module dcnp_scale_stage
    import dcnp_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_op_valid,
    input  t_op         i_op,
    output logic        o_op_ready,
    dcnp_out_if.source  o_res
);

    localparam int TW = 48;
    localparam int CW = (TW > VALUE_BITS) ? TW : VALUE_BITS;
    localparam logic [VALUE_BITS-1:0] MAXV = {1'b0, {(VALUE_BITS-1){1'b1}}};

    // multiply stage
    logic        r_s2_v;
    logic [46:0] r_prod;
    logic [21:0] r_c;
    logic        r_neg;
    logic        r_ok;
    logic        r_over;
    logic [1:0]  r_fmt;

    // result register
    logic                  r_out_v;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_valid_res;
    logic [1:0]            r_fmt_used;
    logic                  r_sat;

    logic                  w_en_out;
    logic                  w_en_s2;
    logic [14:0]           w_k;
    logic [54:0]           w_cprod;
    logic [TW-1:0]         w_t;
    logic                  w_sat;
    logic [VALUE_BITS-1:0] w_mag;
    logic [VALUE_BITS-1:0] w_val;

    assign w_en_out   = !r_out_v || o_res.ready;
    assign w_en_s2    = !r_s2_v || w_en_out;
    assign o_op_ready = w_en_s2;

    always_comb begin
        unique case (i_op.kcode)
            K_INCH:   w_k = KMUL_INCH;
            K_METRIC: w_k = KMUL_METRIC;
            K_TEN:    w_k = KMUL_TEN;
            default:  w_k = '0;
        endcase
    end

    // b * 254 / 100 by reciprocal multiply
    assign w_cprod = 55'(i_op.b) * 55'(CINV);

    assign w_t   = 48'(r_prod) + 48'(r_c);
    assign w_sat = r_ok && (r_over || (CW'(w_t) > CW'(MAXV)));

    always_comb begin
        if (!r_ok) begin
            w_mag = '0;
        end else if (w_sat) begin
            w_mag = MAXV;
        end else begin
            w_mag = VALUE_BITS'(w_t);
        end
        w_val = r_neg ? ('0 - w_mag) : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en_s2) begin
                r_s2_v <= i_op_valid;
            end
            if (w_en_out) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_s2 && i_op_valid) begin
            r_prod <= 47'(i_op.a) * 47'(w_k);
            r_c    <= i_op.inch ? w_cprod[CINV_SHIFT +: 22] : 22'(i_op.b);
            r_neg  <= i_op.neg;
            r_ok   <= i_op.ok;
            r_over <= i_op.over;
            r_fmt  <= i_op.fmt;
        end
        if (w_en_out && r_s2_v) begin
            r_value     <= w_val;
            r_valid_res <= r_ok;
            r_fmt_used  <= r_fmt;
            r_sat       <= w_sat;
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.value       = r_value;
    assign o_res.valid_res   = r_valid_res;
    assign o_res.format_used = r_fmt_used;
    assign o_res.saturated   = r_sat;

endmodule

FILE: rtl/dcnp_checker.sv
// Port-level checks of the parser's result channel, bound to the top level.
module dcnp_checker #(
    parameter int VALUE_BITS = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  i_ready,
    input logic [VALUE_BITS-1:0] i_value,
    input logic                  i_valid_res,
    input logic                  i_saturated
);

    localparam logic [VALUE_BITS-1:0] MAXV = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] NEGV = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_value) && $stable(i_valid_res))
        else $error("result beat changed while stalled");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result beat right after reset");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_valid_res |-> i_value == '0 && !i_saturated)
        else $error("invalid result carries a value");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_saturated |-> i_valid_res && (i_value == MAXV || i_value == NEGV))
        else $error("saturated result not at full scale");

endmodule

bind drill_coordinate_number_parser_top dcnp_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_dcnp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_res.valid),
    .i_ready     (o_res.ready),
    .i_value     (o_res.value),
    .i_valid_res (o_res.valid_res),
    .i_saturated (o_res.saturated)
);
